// ----- rtl/core/ray_box_entry_test_assert.svh -----
// Assertion macros for the ray box entry test
`ifndef RAY_BOX_ENTRY_TEST_ASSERT_SVH
`define RAY_BOX_ENTRY_TEST_ASSERT_SVH

// same-cycle implication
`define RBET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rbet_pkg.sv -----
// Types, constants and lane functions shared by the ray box entry test
`default_nettype none

package rbet_pkg;

  localparam int CoordW    = 32;
  localparam int FracW     = 16;
  localparam int NumW      = CoordW + 1;
  localparam int QW        = 2 * FracW;
  localparam int DistW     = QW - 1;
  localparam int TolW      = 16;
  localparam int NumAxes   = 3;
  localparam int NumFields = 4 * NumAxes;
  localparam int DivSteps  = QW;
  localparam int NumStages = DivSteps + 4;
  localparam int CfgIdxW   = 1;
  localparam int InDataW   = NumFields * CoordW;
  localparam int OutDataW  = ((1 + DistW + 7) / 8) * 8;

  localparam logic [DistW-1:0]    MaxDistReset = {DistW{1'b1}};
  localparam logic [TolW-1:0]     TolReset     = TolW'(66);
  localparam logic signed [QW-1:0] QMax        = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin        = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DISTANCE  = 1'b0,
    REG_HIT_TOLERANCE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] o;
    logic signed [CoordW-1:0] d;
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
  } axis_in_t;

  typedef struct packed {
    logic signed [NumW-1:0]   num_lo;
    logic signed [NumW-1:0]   num_hi;
    logic signed [CoordW-1:0] den;
    logic                     par;
    logic                     pmiss;
  } axis_diff_t;

  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [QW-1:0]     q;
    logic              ovf;
    logic              neg;
  } lane_t;

  typedef struct packed {
    lane_t             lo;
    lane_t             hi;
    logic [CoordW-1:0] dmag;
    logic              par;
    logic              pmiss;
  } axis_div_t;

  typedef struct packed {
    logic signed [QW-1:0] tn;
    logic signed [QW-1:0] tf;
    logic                 miss;
  } axis_span_t;

  typedef struct packed {
    logic [DistW-1:0]     tnear;
    logic signed [QW-1:0] tfar;
    logic                 miss;
  } span_t;

  function automatic lane_t lane_init(input logic signed [NumW-1:0] num,
                                      input logic [CoordW-1:0] dmag,
                                      input logic dneg);
    logic [NumW-1:0]       mag;
    logic [NumW-FracW-1:0] top;
    lane_t                 l;
    mag   = num[NumW-1] ? NumW'(-num) : NumW'(num);
    top   = mag[NumW-1:FracW];
    l.rem = CoordW'(top);
    l.ovf = CoordW'(top) >= dmag;
    l.q   = {mag[FracW-1:0], {FracW{1'b0}}};
    l.neg = num[NumW-1] ^ dneg;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [CoordW-1:0] dmag);
    logic [CoordW:0] sh;
    logic [CoordW:0] diff;
    logic            ge;
    lane_t           r;
    sh    = {l.rem, l.q[QW-1]};
    diff  = sh - {1'b0, dmag};
    ge    = sh >= {1'b0, dmag};
    r     = l;
    r.rem = ge ? diff[CoordW-1:0] : sh[CoordW-1:0];
    r.q   = {l.q[QW-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [QW-1:0] lane_sat(input lane_t l);
    logic signed [QW-1:0] r;
    if (l.neg) begin
      r = (l.ovf || (l.q > {1'b1, {(QW-1){1'b0}}})) ? QMin : QW'(-l.q);
    end else begin
      r = (l.ovf || l.q[QW-1]) ? QMax : l.q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ray_box_entry_test.sv -----
// Top level: pipelined ray versus axis-aligned box entry test, Q16.16
//
//  channel  dir  contents
//  s_*      in   ray origin, direction, box min and max corners
//  m_*      out  hit flag and entry distance
//  cfg_*    in   max_distance, hit_tolerance writes
//
// One transfer accepted per cycle while the skid is empty; 37 register stages.
// The depth is set by the 32 restoring steps of the six parallel divider lanes.
// Pipeline stages advance together; a one-entry skid behind the output
// register takes a result while the output is stalled, then input is held.
// rst clears valid bits and restores the register defaults.
`default_nettype none

module ray_box_entry_test import rbet_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z, 32 bits each
  input  wire logic [InDataW-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // hit [0], entry_distance [31:1]
  output logic [OutDataW-1:0]       m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [DistW-1:0]     cfg_wdata
);

  logic [DistW-1:0]      max_distance;
  logic [TolW-1:0]       hit_tolerance;
  logic                  en;
  logic [NumStages-1:0]  vld;
  axis_in_t [NumAxes-1:0] ain;
  axis_div_t [NumAxes-1:0] dchain [0:DivSteps];
  span_t                 sp;
  logic signed [QW+1:0]  far_tol;
  logic                  res_hit;
  logic [OutDataW-1:0]   res_data;
  logic                  skid_valid;
  logic [OutDataW-1:0]   skid_data;
  logic                  push;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance  <= MaxDistReset;
      hit_tolerance <= TolReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_DISTANCE:  max_distance  <= cfg_wdata;
        REG_HIT_TOLERANCE: hit_tolerance <= cfg_wdata[TolW-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], s_tvalid};
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      ain[a].o  = s_tdata[CoordW*a +: CoordW];
      ain[a].d  = s_tdata[CoordW*(NumAxes+a) +: CoordW];
      ain[a].lo = s_tdata[CoordW*(2*NumAxes+a) +: CoordW];
      ain[a].hi = s_tdata[CoordW*(3*NumAxes+a) +: CoordW];
    end
  end

  rbet_prep u_prep (
    .clk  (clk),
    .en   (en),
    .ain  (ain),
    .adiv (dchain[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    rbet_div_step u_step (
      .clk  (clk),
      .en   (en),
      .din  (dchain[i]),
      .dout (dchain[i+1])
    );
  end

  rbet_resolve u_resolve (
    .clk          (clk),
    .en           (en),
    .max_distance (max_distance),
    .din          (dchain[DivSteps]),
    .sp           (sp)
  );

  always_comb begin
    far_tol  = {{2{sp.tfar[QW-1]}}, sp.tfar} + {{(QW+2-TolW){1'b0}}, hit_tolerance};
    res_hit  = !sp.miss && ($signed({3'b000, sp.tnear}) <= far_tol)
               && (sp.tnear <= max_distance);
    res_data = {(res_hit ? sp.tnear : {DistW{1'b0}}), res_hit};
  end

  assign push = vld[NumStages-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : res_data;
    end else if (push) begin
      skid_data <= res_data;
    end
  end

`include "ray_box_entry_test_assert.svh"

  `RBET_ASSERT_NOW(a_skid_out, clk, rst, skid_valid, m_tvalid, "skid full while output empty")
  `RBET_ASSERT_NOW(a_skid_hold, clk, rst, skid_valid, !s_tready, "input taken with skid full")
  `RBET_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[OutDataW-1:1] == '0,
                   "miss with nonzero entry distance")
  `RBET_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && m_tready, !skid_valid,
                    "skid not drained on output transfer")

endmodule

`default_nettype wire

// ----- rtl/core/rbet_prep.sv -----
// Slab differences, parallel check and divider lane set-up (two stages)
`default_nettype none

module rbet_prep import rbet_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire axis_in_t  [NumAxes-1:0]  ain,
  output axis_div_t      [NumAxes-1:0]  adiv
);

  axis_diff_t [NumAxes-1:0] diff;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++) begin
        diff[a].num_lo <= {ain[a].lo[CoordW-1], ain[a].lo} - {ain[a].o[CoordW-1], ain[a].o};
        diff[a].num_hi <= {ain[a].hi[CoordW-1], ain[a].hi} - {ain[a].o[CoordW-1], ain[a].o};
        diff[a].den    <= ain[a].d;
        diff[a].par    <= ain[a].d == '0;
        diff[a].pmiss  <= (ain[a].o < ain[a].lo) || (ain[a].o > ain[a].hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++) begin
        adiv[a].dmag  <= diff[a].den[CoordW-1] ? CoordW'(-diff[a].den) : CoordW'(diff[a].den);
        adiv[a].lo    <= lane_init(diff[a].num_lo,
                                   diff[a].den[CoordW-1] ? CoordW'(-diff[a].den)
                                                         : CoordW'(diff[a].den),
                                   diff[a].den[CoordW-1]);
        adiv[a].hi    <= lane_init(diff[a].num_hi,
                                   diff[a].den[CoordW-1] ? CoordW'(-diff[a].den)
                                                         : CoordW'(diff[a].den),
                                   diff[a].den[CoordW-1]);
        adiv[a].par   <= diff[a].par;
        adiv[a].pmiss <= diff[a].pmiss;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbet_div_step.sv -----
// One restoring division step for all six lanes
`default_nettype none

module rbet_div_step import rbet_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire axis_div_t [NumAxes-1:0]  din,
  output axis_div_t      [NumAxes-1:0]  dout
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++) begin
        dout[a].lo    <= lane_step(din[a].lo, din[a].dmag);
        dout[a].hi    <= lane_step(din[a].hi, din[a].dmag);
        dout[a].dmag  <= din[a].dmag;
        dout[a].par   <= din[a].par;
        dout[a].pmiss <= din[a].pmiss;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbet_resolve.sv -----
// Quotient saturation, per-axis near/far, then combination over axes
`default_nettype none

module rbet_resolve import rbet_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [DistW-1:0]         max_distance,
  input  wire axis_div_t [NumAxes-1:0]  din,
  output span_t                         sp
);

  axis_span_t [NumAxes-1:0] span;
  logic signed [QW-1:0]     t1 [NumAxes];
  logic signed [QW-1:0]     t2 [NumAxes];
  logic signed [QW-1:0]     maxd_s;
  logic signed [QW-1:0]     n01, n2z, f01, f2m;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      t1[a] = lane_sat(din[a].lo);
      t2[a] = lane_sat(din[a].hi);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++) begin
        if (din[a].par) begin
          span[a].tn <= '0;
          span[a].tf <= QMax;
        end else begin
          span[a].tn <= (t1[a] < t2[a]) ? t1[a] : t2[a];
          span[a].tf <= (t1[a] < t2[a]) ? t2[a] : t1[a];
        end
        span[a].miss <= din[a].par && din[a].pmiss;
      end
    end
  end

  always_comb begin
    maxd_s = {1'b0, max_distance};
    n01    = (span[0].tn > span[1].tn) ? span[0].tn : span[1].tn;
    n2z    = span[2].tn[QW-1] ? '0 : span[2].tn;
    f01    = (span[0].tf < span[1].tf) ? span[0].tf : span[1].tf;
    f2m    = (span[2].tf < maxd_s) ? span[2].tf : maxd_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp.tnear <= (n01 > n2z) ? n01[DistW-1:0] : n2z[DistW-1:0];
      sp.tfar  <= (f01 < f2m) ? f01 : f2m;
      sp.miss  <= span[0].miss || span[1].miss || span[2].miss;
    end
  end

endmodule

`default_nettype wire
